>>> design/ipv4oh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4oh_pkg
// Shared types and constants of the IPv4 octet histogram counter: counter
// width, bank geometry, action and category codes, sequencer states.
// ----------------------------------------------------------------------------
package ipv4oh_pkg;

    localparam int COUNT_WIDTH = 64;
    localparam int HITS_WIDTH  = 64;

    localparam int NUM_CATS   = 3;
    localparam int NUM_DIRS   = 2;
    localparam int NUM_OCTETS = 4;
    localparam int NUM_BINS   = 256;
    localparam int OCTET_W    = 8;

    // one bank per octet position, one row per (category, direction, bin)
    localparam int NUM_ROWS = NUM_CATS * NUM_DIRS * NUM_BINS;
    localparam int ROW_AW   = $clog2(NUM_ROWS);
    localparam int SLOT_W   = ROW_AW - OCTET_W;
    localparam int NUM_SLOTS = NUM_CATS * NUM_DIRS;

    localparam logic [1:0] ACT_COUNT = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] CAT_TOTAL   = 2'd0;
    localparam logic [1:0] CAT_SPOOFED = 2'd1;
    localparam logic [1:0] CAT_ERRATIC = 2'd2;

    localparam logic DIR_SRC = 1'b0;
    localparam logic DIR_DST = 1'b1;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [ROW_AW-1:0] row_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [NUM_OCTETS-1:0][COUNT_WIDTH-1:0] bank_data_t;

    typedef struct packed {
        logic                             rd_en;
        logic                             inc;
        logic [NUM_OCTETS-1:0][ROW_AW-1:0] rd_row;
        logic                             clr_en;
        logic [ROW_AW-1:0]                clr_row;
    } bank_ctrl_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COUNT,
        ST_RD_SRC,
        ST_RD_DST,
        ST_RD_CAP,
        ST_RESULT
    } state_t;

endpackage

>>> design/ipv4oh_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4oh_item_if
// Input channel: one beat is a count, read or clear item.
// ----------------------------------------------------------------------------
interface ipv4oh_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] src_addr;
    logic        src_valid;
    logic [31:0] dst_addr;
    logic        dst_valid;
    logic        is_erratic;
    logic        is_spoofed;
    logic [1:0]  read_category;
    logic [1:0]  read_octet;
    logic [7:0]  read_bin;

    modport source (
        output valid, action, src_addr, src_valid, dst_addr, dst_valid,
               is_erratic, is_spoofed, read_category, read_octet, read_bin,
        input  ready
    );
    modport sink (
        input  valid, action, src_addr, src_valid, dst_addr, dst_valid,
               is_erratic, is_spoofed, read_category, read_octet, read_bin,
        output ready
    );
endinterface

>>> design/ipv4oh_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4oh_result_if
// Output channel: one beat carries the source and destination counts of a bin.
// ----------------------------------------------------------------------------
interface ipv4oh_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] src_hits;
    logic [63:0] dst_hits;

    modport source (
        output valid, src_hits, dst_hits,
        input  ready
    );
    modport sink (
        input  valid, src_hits, dst_hits,
        output ready
    );
endinterface

>>> design/ipv4oh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4oh_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ipv4oh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/ipv4oh_banks.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4oh_banks
// Four counter banks, one per octet position, with the read-modify-write
// incrementer: a read with inc set writes back the count plus one next cycle.
// ----------------------------------------------------------------------------
module ipv4oh_banks (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ipv4oh_pkg::bank_ctrl_t ctrl,
    output ipv4oh_pkg::bank_data_t rd_data
);

    logic                                                   inc_pend_reg;
    logic                                                   inc_pend_next;
    logic [ipv4oh_pkg::NUM_OCTETS-1:0][ipv4oh_pkg::ROW_AW-1:0] wr_row_reg;

    assign inc_pend_next = ctrl.rd_en && ctrl.inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_pend_reg <= 1'b0;
        end
        else
        begin
            inc_pend_reg <= inc_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_row_reg <= ctrl.rd_row;
    end

    for (genvar b = 0; b < ipv4oh_pkg::NUM_OCTETS; b++)
    begin : g_bank
        logic                     we;
        ipv4oh_pkg::row_t         waddr;
        ipv4oh_pkg::count_t       wdata;
        ipv4oh_pkg::count_t       rdata;

        // clear sweep and increment write-back never overlap
        always_comb
        begin
            we    = ctrl.clr_en || inc_pend_reg;
            waddr = ctrl.clr_en ? ctrl.clr_row : wr_row_reg[b];
            wdata = ctrl.clr_en ? '0 : rdata + ipv4oh_pkg::count_t'(1);
        end

        ipv4oh_ram #(
            .WIDTH (ipv4oh_pkg::COUNT_WIDTH),
            .DEPTH (ipv4oh_pkg::NUM_ROWS)
        ) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr (waddr),
            .wdata (wdata),
            .re    (ctrl.rd_en),
            .raddr (ctrl.rd_row[b]),
            .rdata (rdata)
        );

        assign rd_data[b] = rdata;
    end

endmodule

>>> design/ipv4oh_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4oh_seq
// Sequencer: takes item beats, steps through the six category/direction slots
// of a count, the two reads of a read item and the clear sweep, and holds the
// result register.
// ----------------------------------------------------------------------------
module ipv4oh_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    ipv4oh_item_if.sink            item,
    ipv4oh_result_if.source        result,
    output ipv4oh_pkg::bank_ctrl_t ctrl,
    input  ipv4oh_pkg::bank_data_t rd_data
);

    ipv4oh_pkg::state_t state_reg, state_next;
    ipv4oh_pkg::row_t   clr_cnt_reg, clr_cnt_next;
    ipv4oh_pkg::slot_t  slot_reg, slot_next;

    logic [31:0] src_addr_reg, src_addr_next;
    logic [31:0] dst_addr_reg, dst_addr_next;
    logic        src_valid_reg, src_valid_next;
    logic        dst_valid_reg, dst_valid_next;
    logic        erratic_reg, erratic_next;
    logic        spoofed_reg, spoofed_next;
    logic [1:0]  cat_reg, cat_next;
    logic [1:0]  oct_reg, oct_next;
    logic [7:0]  bin_reg, bin_next;

    ipv4oh_pkg::count_t src_hold_reg, src_hold_next;
    ipv4oh_pkg::count_t dst_hold_reg, dst_hold_next;
    ipv4oh_pkg::count_t src_out_reg, src_out_next;
    ipv4oh_pkg::count_t dst_out_reg, dst_out_next;
    logic               out_valid_reg, out_valid_next;

    logic        slot_dir;
    logic [1:0]  slot_cat;
    logic        slot_tag;
    logic        slot_en;
    logic [31:0] slot_addr;
    logic        cat_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ipv4oh_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_addr_reg  <= src_addr_next;
        dst_addr_reg  <= dst_addr_next;
        src_valid_reg <= src_valid_next;
        dst_valid_reg <= dst_valid_next;
        erratic_reg   <= erratic_next;
        spoofed_reg   <= spoofed_next;
        cat_reg       <= cat_next;
        oct_reg       <= oct_next;
        bin_reg       <= bin_next;
        src_hold_reg  <= src_hold_next;
        dst_hold_reg  <= dst_hold_next;
        src_out_reg   <= src_out_next;
        dst_out_reg   <= dst_out_next;
    end

    // slot = category * 2 + direction
    assign slot_dir  = slot_reg[0];
    assign slot_cat  = slot_reg[2:1];
    assign slot_addr = (slot_dir == ipv4oh_pkg::DIR_DST) ? dst_addr_reg : src_addr_reg;
    assign cat_ok    = cat_reg inside {ipv4oh_pkg::CAT_TOTAL, ipv4oh_pkg::CAT_SPOOFED,
                                       ipv4oh_pkg::CAT_ERRATIC};

    always_comb
    begin
        case (slot_cat)
            ipv4oh_pkg::CAT_TOTAL:   slot_tag = 1'b1;
            ipv4oh_pkg::CAT_SPOOFED: slot_tag = spoofed_reg;
            ipv4oh_pkg::CAT_ERRATIC: slot_tag = erratic_reg;
            default:                 slot_tag = 1'b0;
        endcase
        slot_en = slot_tag &&
                  ((slot_dir == ipv4oh_pkg::DIR_DST) ? dst_valid_reg : src_valid_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        slot_next      = slot_reg;
        src_addr_next  = src_addr_reg;
        dst_addr_next  = dst_addr_reg;
        src_valid_next = src_valid_reg;
        dst_valid_next = dst_valid_reg;
        erratic_next   = erratic_reg;
        spoofed_next   = spoofed_reg;
        cat_next       = cat_reg;
        oct_next       = oct_reg;
        bin_next       = bin_reg;
        src_hold_next  = src_hold_reg;
        dst_hold_next  = dst_hold_reg;
        src_out_next   = src_out_reg;
        dst_out_next   = dst_out_reg;
        out_valid_next = out_valid_reg;
        ctrl           = '0;
        item.ready     = 1'b0;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ipv4oh_pkg::ST_CLEAR:
            begin
                ctrl.clr_en  = 1'b1;
                ctrl.clr_row = clr_cnt_reg;
                if (clr_cnt_reg == ipv4oh_pkg::ROW_AW'(ipv4oh_pkg::NUM_ROWS - 1))
                begin
                    state_next = ipv4oh_pkg::ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + ipv4oh_pkg::ROW_AW'(1);
                end
            end

            ipv4oh_pkg::ST_IDLE:
            begin
                item.ready = 1'b1;
                if (item.valid)
                begin
                    src_addr_next  = item.src_addr;
                    dst_addr_next  = item.dst_addr;
                    src_valid_next = item.src_valid;
                    dst_valid_next = item.dst_valid;
                    erratic_next   = item.is_erratic;
                    spoofed_next   = item.is_spoofed;
                    cat_next       = item.read_category;
                    oct_next       = item.read_octet;
                    bin_next       = item.read_bin;
                    case (item.action)
                        ipv4oh_pkg::ACT_COUNT:
                        begin
                            slot_next  = '0;
                            state_next = ipv4oh_pkg::ST_COUNT;
                        end
                        ipv4oh_pkg::ACT_READ:
                        begin
                            state_next = ipv4oh_pkg::ST_RD_SRC;
                        end
                        ipv4oh_pkg::ACT_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            state_next   = ipv4oh_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ipv4oh_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            ipv4oh_pkg::ST_COUNT:
            begin
                // write-back of the last slot lands in the first idle cycle
                ctrl.rd_en = slot_en;
                ctrl.inc   = 1'b1;
                for (int b = 0; b < ipv4oh_pkg::NUM_OCTETS; b++)
                begin
                    ctrl.rd_row[b] = {slot_reg,
                                      slot_addr[31 - b*ipv4oh_pkg::OCTET_W -: ipv4oh_pkg::OCTET_W]};
                end
                if (slot_reg == ipv4oh_pkg::SLOT_W'(ipv4oh_pkg::NUM_SLOTS - 1))
                begin
                    state_next = ipv4oh_pkg::ST_IDLE;
                end
                else
                begin
                    slot_next = slot_reg + ipv4oh_pkg::SLOT_W'(1);
                end
            end

            ipv4oh_pkg::ST_RD_SRC:
            begin
                ctrl.rd_en = cat_ok;
                for (int b = 0; b < ipv4oh_pkg::NUM_OCTETS; b++)
                begin
                    ctrl.rd_row[b] = {cat_reg, ipv4oh_pkg::DIR_SRC, bin_reg};
                end
                state_next = ipv4oh_pkg::ST_RD_DST;
            end

            ipv4oh_pkg::ST_RD_DST:
            begin
                ctrl.rd_en = cat_ok;
                for (int b = 0; b < ipv4oh_pkg::NUM_OCTETS; b++)
                begin
                    ctrl.rd_row[b] = {cat_reg, ipv4oh_pkg::DIR_DST, bin_reg};
                end
                src_hold_next = cat_ok ? rd_data[oct_reg] : '0;
                state_next    = ipv4oh_pkg::ST_RD_CAP;
            end

            ipv4oh_pkg::ST_RD_CAP:
            begin
                dst_hold_next = cat_ok ? rd_data[oct_reg] : '0;
                state_next    = ipv4oh_pkg::ST_RESULT;
            end

            ipv4oh_pkg::ST_RESULT:
            begin
                // wait for the result register to drain
                if (!out_valid_reg || result.ready)
                begin
                    src_out_next   = src_hold_reg;
                    dst_out_next   = dst_hold_reg;
                    out_valid_next = 1'b1;
                    state_next     = ipv4oh_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ipv4oh_pkg::ST_IDLE;
            end
        endcase
    end

    assign result.valid    = out_valid_reg;
    assign result.src_hits = ipv4oh_pkg::HITS_WIDTH'(src_out_reg);
    assign result.dst_hits = ipv4oh_pkg::HITS_WIDTH'(dst_out_reg);

    a_no_rd_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.rd_en && ctrl.clr_en))
        else $error("bank read issued during clear sweep");

    a_clr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ipv4oh_pkg::ST_CLEAR) |->
        (clr_cnt_reg < ipv4oh_pkg::ROW_AW'(ipv4oh_pkg::NUM_ROWS)))
        else $error("clear sweep row out of range");

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ipv4oh_pkg::ST_RESULT))
        else $error("result beat not preceded by a read");

    a_count_starts_at_slot0: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && item.action == ipv4oh_pkg::ACT_COUNT) |=>
        (state_reg == ipv4oh_pkg::ST_COUNT && slot_reg == '0))
        else $error("count beat did not start slot walk");

    a_no_rd_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ipv4oh_pkg::ST_IDLE) |-> !ctrl.rd_en && !ctrl.clr_en)
        else $error("bank access while idle");

endmodule

>>> design/ipv4oh_bank_top_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4oh_bank_top_check
// Port-level checker of the item and result channels: result beats hold while
// stalled, a read beat blocks further items, and its result does not rise too soon.
// ----------------------------------------------------------------------------
module ipv4oh_bank_top_check (
    input logic              clk,
    input logic              rst_n,
    ipv4oh_item_if.sink      item,
    ipv4oh_result_if.source  result
);

    logic item_read;

    assign item_read = item.valid && item.ready && (item.action == ipv4oh_pkg::ACT_READ);

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> (result.valid && $stable(result.src_hits)
                                             && $stable(result.dst_hits)))
        else $error("stalled result beat changed");

    a_no_accept_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        item_read |=> !item.ready)
        else $error("item accepted while a read is in flight");

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        item_read |-> ##1 !$rose(result.valid) ##1 !$rose(result.valid))
        else $error("result beat appeared before the banks were read");

endmodule

>>> design/ipv4_octet_histogram_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_octet_histogram_counter
// Per-octet histograms of IPv4 source and destination addresses in total,
// spoofed and erratic categories, with read-one-bin and clear-all items.
// ----------------------------------------------------------------------------
// The counters sit in four banks, one per octet position, each holding 1536
// rows (category x direction x bin); the four octets of an address update in
// parallel. A count item walks six category/direction slots, one bank
// read-modify-write per cycle, whatever tags or valid flags it carries. A
// read item steps through two bank reads, capture and result load before
// the next item is taken, and waits in the result load while the previous
// result is still in the output register. A clear item, and reset, run a
// sweep that zeroes one row of all four banks per cycle, over all 1536 rows,
// during which no item is accepted. Results come out of an output register,
// so a new item can be taken while a result waits.
// ----------------------------------------------------------------------------
module ipv4_octet_histogram_counter (
    input logic             clk,
    input logic             rst_n,
    ipv4oh_item_if.sink     item,
    ipv4oh_result_if.source result
);

    ipv4oh_pkg::bank_ctrl_t ctrl;
    ipv4oh_pkg::bank_data_t rd_data;

    ipv4oh_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .result  (result),
        .ctrl    (ctrl),
        .rd_data (rd_data)
    );

    ipv4oh_banks u_banks (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .rd_data (rd_data)
    );

    ipv4oh_bank_top_check u_check (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result)
    );

endmodule
